// File: hdl/cmbs_pkg.sv
package cmbs_pkg;

  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_LEFT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_RIGHT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_TOP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_BOTTOM = 3'd6;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic              FILTER_RST = 1'b1;
  localparam logic [6:0]        SIZE_RST   = 7'd64;
  localparam logic signed [31:0] EDGE_LO_RST = 32'sh0000_0000;
  localparam logic signed [31:0] EDGE_HI_RST = 32'sh0040_0000;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        sample;
    logic        white;
    logic [11:0] waddr;
    logic [31:0] wdata;
  } item_t;

  function automatic logic [31:0] lerp_color(input logic [31:0] c1, input logic [31:0] c2,
                                             input logic [7:0] f);
    logic [31:0] r;
    logic [16:0] acc;
    int i;
    r = '0;
    for (i = 0; i < 4; i++) begin
      acc = 17'(c1[8*i +: 8]) * 17'(9'd256 - 9'(f)) + 17'(c2[8*i +: 8]) * 17'(f);
      r[8*i +: 8] = acc[15:8];
    end
    return r;
  endfunction

endpackage

// File: hdl/cmbs_if.sv
interface cmbs_req_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [11:0]        texel_addr;
  logic [31:0]        texel_data;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_z;

  modport source (output valid, cmd, texel_addr, texel_data, coord_x, coord_z, input ready);
  modport sink (input valid, cmd, texel_addr, texel_data, coord_x, coord_z, output ready);
endinterface

interface cmbs_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] color;

  modport source (output valid, color, input ready);
  modport sink (input valid, color, output ready);
endinterface

// File: hdl/cmbs_ram.sv
module cmbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

// File: hdl/color_map_bilinear_sampler.sv
// Channel   Dir  Payload
// req       in   cmd, texel_addr, texel_data, coord_x, coord_z
// rsp       out  color (one item per sample, none per texel write)
// cfg       in   cfg_we, cfg_index, cfg_data
//
// One item enters per cycle while the pipeline is not held. A result is offered once its item
// has passed the bounds and offset stages, the two pipelined dividers of quotient width QW (15 for
// a 64 by 64 map), the store read and the filter stages; each divider stage retires one bit.
// Texel writes travel the pipeline and commit at the read stage, so reads and writes keep
// their order. Two copies of the store, each with two read ports, give four texels a cycle
// unless held. Reset clears the valid bits and configuration registers, not the data
// registers or the texel store. When a result is not taken, the whole pipeline holds.
module color_map_bilinear_sampler import cmbs_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  cmbs_req_if.sink              req,
  cmbs_rsp_if.source            rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = $clog2(MAXD + 1);
  localparam int QW    = $clog2((2 * MAXD + 1) * 128);
  localparam int NW    = WW + 41;
  localparam int RW    = 34;
  localparam int DVW   = 33;
  localparam int CBW   = QW - 8;
  localparam int PS    = QW + 4;
  localparam int LEN   = QW + 8;

  logic               filter_mode;
  logic [6:0]         map_width;
  logic [6:0]         map_height;
  logic signed [31:0] bound_left;
  logic signed [31:0] bound_right;
  logic signed [31:0] bound_top;
  logic signed [31:0] bound_bottom;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= FILTER_RST;
      map_width    <= SIZE_RST;
      map_height   <= SIZE_RST;
      bound_left   <= EDGE_LO_RST;
      bound_right  <= EDGE_HI_RST;
      bound_top    <= EDGE_LO_RST;
      bound_bottom <= EDGE_HI_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FILTER_MODE:  filter_mode  <= cfg_data[0];
        CFG_MAP_WIDTH:    map_width    <= cfg_data[6:0];
        CFG_MAP_HEIGHT:   map_height   <= cfg_data[6:0];
        CFG_BOUND_LEFT:   bound_left   <= cfg_data;
        CFG_BOUND_RIGHT:  bound_right  <= cfg_data;
        CFG_BOUND_TOP:    bound_top    <= cfg_data;
        CFG_BOUND_BOTTOM: bound_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [WW-1:0] w_cl;
  logic [WW-1:0] h_cl;

  always_comb begin
    if (map_width == '0) begin
      w_cl = WW'(1);
    end else if (32'(map_width) > 32'(MAX_WIDTH)) begin
      w_cl = WW'(MAX_WIDTH);
    end else begin
      w_cl = WW'(map_width);
    end
    if (map_height == '0) begin
      h_cl = WW'(1);
    end else if (32'(map_height) > 32'(MAX_HEIGHT)) begin
      h_cl = WW'(MAX_HEIGHT);
    end else begin
      h_cl = WW'(map_height);
    end
  end

  logic en;
  assign en = !rsp.valid || rsp.ready;
  assign req.ready = en && !rst;

  logic  vld_q  [LEN];
  item_t item_q [LEN];
  item_t item_next [LEN];

  logic signed [31:0] x0;
  logic signed [31:0] z0;
  logic               oob;
  logic               edge_bad;

  always_comb begin
    item_next[0].sample = (req.cmd == CMD_SAMPLE);
    item_next[0].white  = 1'b0;
    item_next[0].waddr  = req.texel_addr;
    item_next[0].wdata  = req.texel_data;
    for (int i = 1; i < LEN; i++) begin
      item_next[i] = item_q[i-1];
    end
    item_next[1].white  = oob;
    item_next[PS].white = item_q[PS-1].white | edge_bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEN; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= req.valid;
      for (int i = 1; i < LEN; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LEN; i++) begin
        item_q[i] <= item_next[i];
      end
    end
  end

  // Bounds test and offsets.
  logic [31:0] dx1, dz1, rx1, rz1;

  assign oob = (x0 < bound_left) || (x0 >= bound_right) ||
               (z0 < bound_top) || (z0 >= bound_bottom);

  always_ff @(posedge clk) begin
    if (en) begin
      x0  <= req.coord_x;
      z0  <= req.coord_z;
      dx1 <= 32'(x0 - bound_left);
      dz1 <= 32'(z0 - bound_top);
      rx1 <= 32'(bound_right - bound_left);
      rz1 <= 32'(bound_bottom - bound_top);
    end
  end

  logic [WW+31:0] px2, pz2;
  logic [31:0]    rx2, rz2;

  always_ff @(posedge clk) begin
    if (en) begin
      px2 <= (WW+32)'(w_cl) * (WW+32)'(dx1);
      pz2 <= (WW+32)'(h_cl) * (WW+32)'(dz1);
      rx2 <= rx1;
      rz2 <= rz1;
    end
  end

  // Numerator is (2*w*dx + rx) * 256 in bilinear mode, 2*w*dx*256 in nearest mode,
  // over a divisor of 2*rx; the quotient carries eight fraction bits.
  logic [NW-1:0] nx, nz;

  assign nx = {(NW-8)'({px2, 1'b0}) + (NW-8)'(filter_mode ? rx2 : 32'd0), 8'h00};
  assign nz = {(NW-8)'({pz2, 1'b0}) + (NW-8)'(filter_mode ? rz2 : 32'd0), 8'h00};

  logic [RW-1:0]  rem_x [QW+1];
  logic [RW-1:0]  rem_z [QW+1];
  logic [QW-1:0]  rq_x  [QW+1];
  logic [QW-1:0]  rq_z  [QW+1];
  logic [DVW-1:0] dv_x  [QW+1];
  logic [DVW-1:0] dv_z  [QW+1];
  logic [RW-1:0]  rem_x_next [QW+1];
  logic [RW-1:0]  rem_z_next [QW+1];
  logic [QW-1:0]  rq_x_next  [QW+1];
  logic [QW-1:0]  rq_z_next  [QW+1];
  logic [RW-1:0]  tx [QW+1];
  logic [RW-1:0]  tz [QW+1];
  logic           gx [QW+1];
  logic           gz [QW+1];

  always_comb begin
    rem_x_next[0] = RW'(nx >> QW);
    rem_z_next[0] = RW'(nz >> QW);
    rq_x_next[0]  = nx[QW-1:0];
    rq_z_next[0]  = nz[QW-1:0];
    tx[0] = '0;
    tz[0] = '0;
    gx[0] = 1'b0;
    gz[0] = 1'b0;
    for (int k = 1; k <= QW; k++) begin
      tx[k] = {rem_x[k-1][RW-2:0], rq_x[k-1][QW-1]};
      tz[k] = {rem_z[k-1][RW-2:0], rq_z[k-1][QW-1]};
      gx[k] = (tx[k] >= RW'(dv_x[k-1]));
      gz[k] = (tz[k] >= RW'(dv_z[k-1]));
      rem_x_next[k] = gx[k] ? tx[k] - RW'(dv_x[k-1]) : tx[k];
      rem_z_next[k] = gz[k] ? tz[k] - RW'(dv_z[k-1]) : tz[k];
      rq_x_next[k]  = {rq_x[k-1][QW-2:0], gx[k]};
      rq_z_next[k]  = {rq_z[k-1][QW-2:0], gz[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= QW; k++) begin
        rem_x[k] <= rem_x_next[k];
        rem_z[k] <= rem_z_next[k];
        rq_x[k]  <= rq_x_next[k];
        rq_z[k]  <= rq_z_next[k];
      end
      dv_x[0] <= {rx2, 1'b0};
      dv_z[0] <= {rz2, 1'b0};
      for (int k = 1; k <= QW; k++) begin
        dv_x[k] <= dv_x[k-1];
        dv_z[k] <= dv_z[k-1];
      end
    end
  end

  // Texel position and grid edge test.
  logic [CBW-1:0] colb, rowb;
  logic [CBW-1:0] col_p, row_p;
  logic [7:0]     fx_p, fz_p;

  assign colb = rq_x[QW][QW-1:8];
  assign rowb = rq_z[QW][QW-1:8];
  assign edge_bad = filter_mode &&
                    ((colb == '0) || (32'(colb) >= 32'(w_cl)) ||
                     (rowb == '0) || (32'(rowb) >= 32'(h_cl)));

  always_ff @(posedge clk) begin
    if (en) begin
      col_p <= filter_mode ? colb - CBW'(1) : colb;
      row_p <= filter_mode ? rowb - CBW'(1) : rowb;
      fx_p  <= rq_x[QW][7:0];
      fz_p  <= rq_z[QW][7:0];
    end
  end

  // Store access.
  logic [31:0]   base;
  logic [AW-1:0] a00, a01, a10, a11;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic [31:0]   t00, t01, t10, t11;

  assign base    = 32'(row_p) * 32'(MAX_WIDTH) + 32'(col_p);
  assign a00     = AW'(base);
  assign a01     = AW'(base + 32'd1);
  assign a10     = AW'(base + 32'(MAX_WIDTH));
  assign a11     = AW'(base + 32'(MAX_WIDTH) + 32'd1);
  assign wr_addr = AW'(32'(item_q[PS].waddr));
  assign wr_en   = en && vld_q[PS] && !item_q[PS].sample &&
                   (32'(item_q[PS].waddr) < 32'(DEPTH));

  cmbs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_top (
    .clk    (clk),
    .we     (wr_en),
    .waddr  (wr_addr),
    .wdata  (item_q[PS].wdata),
    .re     (en),
    .raddr0 (a00),
    .raddr1 (a01),
    .rdata0 (t00),
    .rdata1 (t01)
  );

  cmbs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_bot (
    .clk    (clk),
    .we     (wr_en),
    .waddr  (wr_addr),
    .wdata  (item_q[PS].wdata),
    .re     (en),
    .raddr0 (a10),
    .raddr1 (a11),
    .rdata0 (t10),
    .rdata1 (t11)
  );

  logic [7:0] fx_d, fz_d;

  always_ff @(posedge clk) begin
    if (en) begin
      fx_d <= fx_p;
      fz_d <= fz_p;
    end
  end

  // Filtering.
  logic [31:0] top_h, bot_h, near_h;
  logic [7:0]  fz_h;
  logic [31:0] color_q;

  always_ff @(posedge clk) begin
    if (en) begin
      top_h   <= lerp_color(t00, t01, fx_d);
      bot_h   <= lerp_color(t10, t11, fx_d);
      near_h  <= t00;
      fz_h    <= fz_d;
      color_q <= item_q[LEN-2].white ? ALL_ONES :
                 (filter_mode ? lerp_color(top_h, bot_h, fz_h) : near_h);
    end
  end

  assign rsp.valid = vld_q[LEN-1] && item_q[LEN-1].sample;
  assign rsp.color = color_q;

endmodule
